/* rtl/brf_pkg.sv */
// ----------------------------------------------------------------------------
// brf_pkg
// shared types, command codes, mode codes and the bank map of the banked
// register file
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int NUM_PHYS = 37;

  typedef logic [5:0]  entry_t;
  typedef logic [4:0]  col_t;
  typedef logic [4:0]  mode_t;
  typedef logic [31:0] word_t;

  localparam entry_t CPSR_ENTRY = 6'd16;
  localparam col_t   SPSR_COL   = 5'd16;

  typedef enum logic [2:0] {
    CMD_READ       = 3'd0,
    CMD_WRITE      = 3'd1,
    CMD_USER_READ  = 3'd2,
    CMD_USER_WRITE = 3'd3,
    CMD_READ_CPSR  = 3'd4,
    CMD_WRITE_CPSR = 3'd5,
    CMD_READ_SPSR  = 3'd6,
    CMD_WRITE_SPSR = 3'd7
  } cmd_e;

  localparam mode_t MODE_USR = 5'h10;
  localparam mode_t MODE_FIQ = 5'h11;
  localparam mode_t MODE_IRQ = 5'h12;
  localparam mode_t MODE_SVC = 5'h13;
  localparam mode_t MODE_ABT = 5'h17;
  localparam mode_t MODE_UND = 5'h1B;
  localparam mode_t MODE_SYS = 5'h1F;

  // first banked entry (r13) of the modes that bank only r13, r14 and spsr
  localparam entry_t IRQ_BASE = 6'd26;
  localparam entry_t SVC_BASE = 6'd17;
  localparam entry_t ABT_BASE = 6'd20;
  localparam entry_t UND_BASE = 6'd23;
  localparam entry_t FIQ_R8   = 6'd29;
  localparam entry_t FIQ_SPSR = 6'd36;

  // decoded access passed from the decoder to the storage side
  typedef struct packed {
    entry_t entry;
    logic   wr_en;
    logic   is_read;
    logic   refused;
    logic   mode_wr;
  } access_t;

  function automatic logic valid_mode(input mode_t code);
    logic ok;
    case (code)
      MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
      MODE_ABT, MODE_UND, MODE_SYS: ok = 1'b1;
      default:                      ok = 1'b0;
    endcase
    return ok;
  endfunction

  // physical entry for a mode and a column (r0..r15, or spsr column)
  function automatic entry_t bank_entry(input mode_t mode, input col_t col);
    entry_t base;
    entry_t e;
    logic   small_bank;
    base       = SVC_BASE;
    small_bank = 1'b1;
    e          = entry_t'(col);
    case (mode)
      MODE_IRQ: base = IRQ_BASE;
      MODE_SVC: base = SVC_BASE;
      MODE_ABT: base = ABT_BASE;
      MODE_UND: base = UND_BASE;
      default:  small_bank = 1'b0;
    endcase
    if (small_bank) begin
      if (col == 5'd13) begin
        e = base;
      end else if (col == 5'd14) begin
        e = base + 6'd1;
      end else if (col == SPSR_COL) begin
        e = base + 6'd2;
      end
    end else if (mode == MODE_FIQ) begin
      if (col >= 5'd8 && col <= 5'd14) begin
        e = FIQ_R8 + (entry_t'(col) - 6'd8);
      end else if (col == SPSR_COL) begin
        e = FIQ_SPSR;
      end
    end else if (col == SPSR_COL) begin
      // no spsr in user or system mode, never accessed
      e = '0;
    end
    return e;
  endfunction

endpackage

/* rtl/brf_decode.sv */
// ----------------------------------------------------------------------------
// brf_decode
// turns a command, register number and current mode into a physical entry,
// access kind, refusal and mode update
// ----------------------------------------------------------------------------
module brf_decode (
  input  brf_pkg::cmd_e    command,
  input  logic [3:0]       reg_index,
  input  brf_pkg::word_t   write_value,
  input  brf_pkg::mode_t   mode,
  output brf_pkg::access_t acc
);
  import brf_pkg::*;

  logic has_spsr;
  col_t reg_col;

  assign has_spsr = (mode != MODE_USR) && (mode != MODE_SYS);
  assign reg_col  = {1'b0, reg_index};

  always_comb begin
    acc         = '0;
    acc.entry   = bank_entry(mode, reg_col);
    case (command)
      CMD_READ: begin
        acc.is_read = 1'b1;
      end
      CMD_WRITE: begin
        acc.wr_en = 1'b1;
      end
      CMD_USER_READ: begin
        acc.is_read = 1'b1;
        acc.entry   = entry_t'(reg_index);
        acc.refused = (mode != MODE_USR);
      end
      CMD_USER_WRITE: begin
        acc.entry   = entry_t'(reg_index);
        acc.wr_en   = (mode == MODE_USR);
        acc.refused = (mode != MODE_USR);
      end
      CMD_READ_CPSR: begin
        acc.is_read = 1'b1;
        acc.entry   = CPSR_ENTRY;
      end
      CMD_WRITE_CPSR: begin
        acc.entry   = CPSR_ENTRY;
        acc.wr_en   = 1'b1;
        acc.mode_wr = valid_mode(write_value[4:0]);
      end
      CMD_READ_SPSR: begin
        acc.is_read = 1'b1;
        acc.entry   = bank_entry(mode, SPSR_COL);
        acc.refused = !has_spsr;
      end
      CMD_WRITE_SPSR: begin
        acc.entry   = bank_entry(mode, SPSR_COL);
        acc.wr_en   = has_spsr;
        acc.refused = !has_spsr;
      end
      default: begin
        acc = '0;
      end
    endcase
  end

endmodule

/* rtl/banked_register_file.sv */
// ----------------------------------------------------------------------------
// banked_register_file
// 37-entry banked register file with mode-dependent register mapping
// ----------------------------------------------------------------------------
// One transaction is taken per clock: busy is always low, so start may be held
// high every cycle. Each transaction gives exactly one result, shown with done
// for one cycle in the cycle after the transaction is taken, and the receiver
// cannot stall it. The single-port entry memory sets this: the access is
// decoded and the entry written or read at the accepting edge, and the read
// data comes out of the memory register while done is high. A write is finished
// by that edge, so the next transaction always sees it; a cpsr write with a
// valid mode code takes effect for the very next transaction. The entries need
// no clearing pass after reset: a written flag per entry makes untouched
// entries read as zero.
module banked_register_file (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  brf_pkg::cmd_e   command,
  input  logic [3:0]      reg_index,
  input  brf_pkg::word_t  write_value,
  output logic            done,
  output brf_pkg::word_t  read_data,
  output logic            refused
);
  import brf_pkg::*;

  // entry storage with a registered read
  word_t             regs_mem [NUM_PHYS];
  logic [NUM_PHYS-1:0] written;

  mode_t   mode;
  access_t acc;
  logic    accept;

  // result stage
  word_t rd_data;
  logic  rd_valid;
  logic  out_read;
  logic  out_refused;

  // never stalls: every access finishes in the memory cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  brf_decode u_decode (
    .command     (command),
    .reg_index   (reg_index),
    .write_value (write_value),
    .mode        (mode),
    .acc         (acc)
  );

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (accept && acc.wr_en) begin
      regs_mem[acc.entry] <= write_value;
    end
    if (accept) begin
      rd_data <= regs_mem[acc.entry];
    end
  end

  // written flags stand in for the reset-to-zero of the entries
  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      rd_valid <= 1'b0;
    end else if (accept) begin
      rd_valid <= written[acc.entry];
      if (acc.wr_en) begin
        written[acc.entry] <= 1'b1;
      end
    end
  end

  // current mode, switched by a cpsr write carrying a valid mode code
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_USR;
    end else if (accept && acc.mode_wr) begin
      mode <= write_value[4:0];
    end
  end

  // result strobe and kind of result
  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      out_read    <= 1'b0;
      out_refused <= 1'b0;
    end else begin
      done        <= accept;
      out_read    <= acc.is_read;
      out_refused <= acc.refused;
    end
  end

  // refused reads give all ones, writes give zero
  always_comb begin
    if (!out_read) begin
      read_data = '0;
    end else if (out_refused) begin
      read_data = '1;
    end else if (rd_valid) begin
      read_data = rd_data;
    end else begin
      read_data = '0;
    end
  end

  assign refused = out_refused;

  // one result for every transaction, in the cycle after it
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("transaction without result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result without transaction");

  // mode register only ever holds a legal mode code
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    valid_mode(mode))
    else $error("illegal mode held");

  // valid cpsr write switches the mode for the next transaction
  a_mode_switch: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_WRITE_CPSR && valid_mode(write_value[4:0]))
      |=> mode == $past(write_value[4:0]))
    else $error("mode not switched by cpsr write");

  // refused results carry all ones or zero
  a_refused_data: assert property (@(posedge clk) disable iff (rst)
    (done && refused) |-> (read_data == '1 || read_data == '0))
    else $error("refused result carries data");

endmodule
